// ===== sv/mrac_pkg.sv =====
package mrac_pkg;

  localparam int DataW  = 32;
  localparam int GainW  = 31;
  localparam int WideW  = 50;
  localparam int CfgIdxW = 3;

  // item kinds; the unused code behaves as a plain clear
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_RELOAD = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODEL_STEP     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_RATE_P    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_RATE_I    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_KP     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_KI     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OUTPUT_LIMIT   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_INTEGRAL_LIMIT = 3'd7;

  localparam logic [DataW-1:0] RST_SAMPLE_PERIOD  = 32'd4294967;
  localparam logic [DataW-1:0] RST_MODEL_STEP     = 32'd42949673;
  localparam logic [GainW-1:0] RST_GAIN_RATE_P    = 31'd0;
  localparam logic [GainW-1:0] RST_GAIN_RATE_I    = 31'd0;
  localparam logic [GainW-1:0] RST_INITIAL_KP     = 31'd65536;
  localparam logic [GainW-1:0] RST_INITIAL_KI     = 31'd0;
  localparam logic [GainW-1:0] RST_OUTPUT_LIMIT   = 31'd6553600;
  localparam logic [GainW-1:0] RST_INTEGRAL_LIMIT = 31'd65536000;

  localparam logic signed [WideW-1:0] SatMax  = 50'sd2147483647;
  localparam logic signed [WideW-1:0] SatMin  = -50'sd2147483648;
  localparam logic signed [WideW-1:0] GainMax = 50'sd2147483647;

  typedef struct packed {
    logic [DataW-1:0] sample_period;
    logic [DataW-1:0] model_step;
    logic [GainW-1:0] gain_rate_p;
    logic [GainW-1:0] gain_rate_i;
    logic [GainW-1:0] initial_kp;
    logic [GainW-1:0] initial_ki;
    logic [GainW-1:0] output_limit;
    logic [GainW-1:0] integral_limit;
  } cfg_t;

  function automatic logic signed [WideW-1:0] sx50(input logic signed [DataW-1:0] x);
    sx50 = {{(WideW-DataW){x[DataW-1]}}, x};
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] x);
    if (x > SatMax) begin
      sat32 = 32'sh7fffffff;
    end else if (x < SatMin) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[DataW-1:0];
    end
  endfunction

  function automatic logic signed [DataW-1:0] clamp_sym(input logic signed [WideW-1:0] x,
                                                        input logic [GainW-1:0] lim);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = $signed({{(WideW-GainW){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      clamp_sym = hi[DataW-1:0];
    end else if (x < lo) begin
      clamp_sym = lo[DataW-1:0];
    end else begin
      clamp_sym = x[DataW-1:0];
    end
  endfunction

  function automatic logic [GainW-1:0] clamp_gain(input logic signed [WideW-1:0] x);
    if (x < 0) begin
      clamp_gain = '0;
    end else if (x > GainMax) begin
      clamp_gain = GainMax[GainW-1:0];
    end else begin
      clamp_gain = x[GainW-1:0];
    end
  endfunction

endpackage

// ===== sv/mrac_ifs.sv =====
interface mrac_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [31:0]       setpoint;
  logic signed [31:0]       feedback;

  modport source(output valid, kind, setpoint, feedback, input ready);
  modport sink(input valid, kind, setpoint, feedback, output ready);
endinterface

interface mrac_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       drive;
  logic signed [31:0]       model_output;
  logic [30:0]              gain_p;
  logic [30:0]              gain_i;

  modport source(output valid, drive, model_output, gain_p, gain_i, input ready);
  modport sink(input valid, drive, model_output, gain_p, gain_i, output ready);
endinterface

// ===== sv/mit_rule_adaptive_pi_controller_top.sv =====
// Channel  Dir  Handshake       Payload
// in_ch    in   valid/ready     kind[1:0], setpoint[31:0] s, feedback[31:0] s
// out_ch   out  valid/ready     drive[31:0] s, model_output[31:0] s, gain_p[30:0], gain_i[30:0]
// cfg_*    in   write enable    cfg_index[2:0], cfg_wdata[31:0]
//
// A control sample runs ten products through one registered 33x33 multiplier:
// 11 sequencer steps plus a result step; a new beat is taken only after the result step.
// Clear and reload beats skip the multiplier and go straight to the result step.
// in_ch is ready only when the sequencer is idle; the result step waits while a
// previous result has not been taken on out_ch. Reset (sync, active low) loads
// the register defaults, zeroes model and integral and loads the initial gains.
module mit_rule_adaptive_pi_controller_top (
  input  logic                         clk,
  input  logic                         rst_n,
  mrac_in_if.sink                      in_ch,
  mrac_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [mrac_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mrac_pkg::DataW-1:0]   cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // step names give the product issued in that step
  localparam logic [3:0] S_MODEL_DECAY = 4'd0;
  localparam logic [3:0] S_MODEL_DRIVE = 4'd1;
  localparam logic [3:0] S_ERR_TS      = 4'd2;
  localparam logic [3:0] S_EM_TS       = 4'd3;
  localparam logic [3:0] S_KP_E        = 4'd4;
  localparam logic [3:0] S_KI_INT      = 4'd5;
  localparam logic [3:0] S_RATE_P      = 4'd6;
  localparam logic [3:0] S_RATE_I      = 4'd7;
  localparam logic [3:0] S_DELTA_P     = 4'd8;
  localparam logic [3:0] S_DELTA_I     = 4'd9;
  localparam logic [3:0] S_LAST        = 4'd10;

  mrac_pkg::cfg_t cfg;

  logic [1:0]         state_r, state_nxt;
  logic [3:0]         step_r, step_nxt;
  logic               out_valid_r;

  logic signed [31:0] sp_r, fb_r, e_r, em_r, emt_r;
  logic signed [31:0] model_r, integ_r, drive_r, ratep_r, ratei_r;
  logic signed [34:0] t1_r;
  logic signed [47:0] kpe_r;
  logic [30:0]        kp_r, ki_r;

  logic signed [31:0] out_drive_r, out_model_r;
  logic [30:0]        out_gp_r, out_gi_r;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod, prod_neg, sh32, sh16, neg_sh32;
  logic signed [49:0] sh32_w, sh16_w;
  logic signed [34:0] t1_nxt, model_sum;
  logic signed [31:0] model_nxt, em_nxt, e_nxt, integ_nxt, drive_nxt, ratep_nxt;
  logic [30:0]        kp_nxt, ki_nxt;
  logic               in_acc, out_load;

  mrac_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .idx   (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  mrac_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      S_MODEL_DECAY: begin
        op_a = $signed({1'b0, cfg.model_step});
        op_b = {model_r[31], model_r};
      end
      S_MODEL_DRIVE: begin
        op_a = $signed({1'b0, cfg.model_step});
        op_b = {sp_r[31], sp_r};
      end
      S_ERR_TS: begin
        op_a = {e_r[31], e_r};
        op_b = $signed({1'b0, cfg.sample_period});
      end
      S_EM_TS: begin
        op_a = {em_r[31], em_r};
        op_b = $signed({1'b0, cfg.sample_period});
      end
      S_KP_E: begin
        op_a = $signed({2'b00, kp_r});
        op_b = {e_r[31], e_r};
      end
      S_KI_INT: begin
        op_a = $signed({2'b00, ki_r});
        op_b = {integ_r[31], integ_r};
      end
      S_RATE_P: begin
        op_a = $signed({2'b00, cfg.gain_rate_p});
        op_b = {emt_r[31], emt_r};
      end
      S_RATE_I: begin
        op_a = $signed({2'b00, cfg.gain_rate_i});
        op_b = {emt_r[31], emt_r};
      end
      S_DELTA_P: begin
        op_a = {ratep_r[31], ratep_r};
        op_b = {e_r[31], e_r};
      end
      S_DELTA_I: begin
        op_a = {ratei_r[31], ratei_r};
        op_b = {integ_r[31], integ_r};
      end
      default: ;
    endcase
  end

  // (2^32 - m) * x >> 32 is taken as x + ((-(m * x)) >>> 32)
  assign prod_neg = -prod;
  assign neg_sh32 = prod_neg >>> 32;
  assign sh32     = prod >>> 32;
  assign sh16     = prod >>> 16;
  assign sh32_w   = $signed(sh32[49:0]);
  assign sh16_w   = $signed(sh16[49:0]);

  assign t1_nxt    = $signed(neg_sh32[34:0]) + $signed({{3{model_r[31]}}, model_r});
  assign model_sum = t1_r + $signed(sh32[34:0]);
  assign model_nxt = mrac_pkg::sat32($signed({{15{model_sum[34]}}, model_sum}));
  assign em_nxt    = mrac_pkg::sat32(mrac_pkg::sx50(model_nxt) - mrac_pkg::sx50(fb_r));
  assign e_nxt     = mrac_pkg::sat32(mrac_pkg::sx50(in_ch.setpoint)
                                     - mrac_pkg::sx50(in_ch.feedback));
  assign integ_nxt = mrac_pkg::clamp_sym(mrac_pkg::sx50(integ_r) + sh32_w,
                                         cfg.integral_limit);
  assign drive_nxt = mrac_pkg::clamp_sym($signed({{2{kpe_r[47]}}, kpe_r}) + sh16_w,
                                         cfg.output_limit);
  assign ratep_nxt = mrac_pkg::sat32(sh16_w);
  assign kp_nxt    = mrac_pkg::clamp_gain($signed({19'b0, kp_r}) - sh16_w);
  assign ki_nxt    = mrac_pkg::clamp_gain($signed({19'b0, ki_r}) - sh16_w);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          step_nxt  = S_MODEL_DECAY;
          state_nxt = (in_ch.kind == mrac_pkg::KIND_SAMPLE) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 4'd1;
        if (step_r == S_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_MODEL_DECAY;
      out_valid_r <= 1'b0;
      model_r     <= '0;
      integ_r     <= '0;
      kp_r        <= mrac_pkg::RST_INITIAL_KP;
      ki_r        <= mrac_pkg::RST_INITIAL_KI;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_ch.kind != mrac_pkg::KIND_SAMPLE) begin
          model_r <= '0;
          integ_r <= '0;
          if (in_ch.kind == mrac_pkg::KIND_RELOAD) begin
            kp_r <= cfg.initial_kp;
            ki_r <= cfg.initial_ki;
          end
        end
      end else if (state_r == ST_RUN) begin
        case (step_r)
          S_ERR_TS:  model_r <= model_nxt;
          S_EM_TS:   integ_r <= integ_nxt;
          S_DELTA_I: kp_r    <= kp_nxt;
          S_LAST:    ki_r    <= ki_nxt;
          default: ;
        endcase
      end
    end
  end

  // datapath payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sp_r    <= in_ch.setpoint;
      fb_r    <= in_ch.feedback;
      e_r     <= e_nxt;
      drive_r <= '0;
    end else if (state_r == ST_RUN) begin
      case (step_r)
        S_MODEL_DRIVE: t1_r    <= t1_nxt;
        S_ERR_TS:      em_r    <= em_nxt;
        S_KP_E:        emt_r   <= sh32_w[31:0];
        S_KI_INT:      kpe_r   <= sh16_w[47:0];
        S_RATE_P:      drive_r <= drive_nxt;
        S_RATE_I:      ratep_r <= ratep_nxt;
        S_DELTA_P:     ratei_r <= ratep_nxt;
        default: ;
      endcase
    end
    if (out_load) begin
      out_drive_r <= drive_r;
      out_model_r <= model_r;
      out_gp_r    <= kp_r;
      out_gi_r    <= ki_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive        = out_drive_r;
  assign out_ch.model_output = out_model_r;
  assign out_ch.gain_p       = out_gp_r;
  assign out_ch.gain_i       = out_gi_r;

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after an accepted beat");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> step_r <= S_LAST)
    else $error("sequencer step ran past the last step");

  a_done_presents: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_valid_r |=> out_valid_r && state_r == ST_IDLE)
    else $error("result step did not present a result");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.kind != mrac_pkg::KIND_SAMPLE |=> model_r == '0 && integ_r == '0)
    else $error("clear beat left model or integral set");

endmodule

// ===== sv/mrac_cfg.sv =====
module mrac_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         we,
  input  logic [mrac_pkg::CfgIdxW-1:0] idx,
  input  logic [mrac_pkg::DataW-1:0]   wdata,
  output mrac_pkg::cfg_t               cfg
);

  mrac_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period  <= mrac_pkg::RST_SAMPLE_PERIOD;
      cfg_r.model_step     <= mrac_pkg::RST_MODEL_STEP;
      cfg_r.gain_rate_p    <= mrac_pkg::RST_GAIN_RATE_P;
      cfg_r.gain_rate_i    <= mrac_pkg::RST_GAIN_RATE_I;
      cfg_r.initial_kp     <= mrac_pkg::RST_INITIAL_KP;
      cfg_r.initial_ki     <= mrac_pkg::RST_INITIAL_KI;
      cfg_r.output_limit   <= mrac_pkg::RST_OUTPUT_LIMIT;
      cfg_r.integral_limit <= mrac_pkg::RST_INTEGRAL_LIMIT;
    end else if (we) begin
      case (idx)
        mrac_pkg::CFG_SAMPLE_PERIOD:  cfg_r.sample_period  <= wdata;
        mrac_pkg::CFG_MODEL_STEP:     cfg_r.model_step     <= wdata;
        mrac_pkg::CFG_GAIN_RATE_P:    cfg_r.gain_rate_p    <= wdata[mrac_pkg::GainW-1:0];
        mrac_pkg::CFG_GAIN_RATE_I:    cfg_r.gain_rate_i    <= wdata[mrac_pkg::GainW-1:0];
        mrac_pkg::CFG_INITIAL_KP:     cfg_r.initial_kp     <= wdata[mrac_pkg::GainW-1:0];
        mrac_pkg::CFG_INITIAL_KI:     cfg_r.initial_ki     <= wdata[mrac_pkg::GainW-1:0];
        mrac_pkg::CFG_OUTPUT_LIMIT:   cfg_r.output_limit   <= wdata[mrac_pkg::GainW-1:0];
        mrac_pkg::CFG_INTEGRAL_LIMIT: cfg_r.integral_limit <= wdata[mrac_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/mrac_mul.sv =====
// shared signed 33x33 multiplier, product registered
module mrac_mul (
  input  logic                clk,
  input  logic signed [32:0]  op_a,
  input  logic signed [32:0]  op_b,
  output logic signed [65:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule
